FILE: sv/vdl_pkg.sv
// vdl_pkg: shared constants and types of the vertex diffuse lighting core.
// No dependencies; imported by vdl_dot and vertex_diffuse_lighting_core.
package vdl_pkg;

    localparam int MAX_LIGHTS    = 6;
    localparam int FRACTION_BITS = 10;

    localparam int COMP_W   = 12;
    localparam int COLOR_W  = 8;
    localparam int RGB_W    = 3 * COLOR_W;
    localparam int PROD_W   = 2 * COMP_W;
    localparam int SUM_W    = PROD_W + 2;
    localparam int DOT_W    = PROD_W;
    localparam int CPROD_W  = COLOR_W + DOT_W;
    localparam int ACC_W    = CPROD_W + 3;
    localparam int SHIFT    = 2 * FRACTION_BITS;
    localparam int NPAIR    = (MAX_LIGHTS + 1) / 2;

    localparam int CNT_W     = 3;
    localparam int CFG_IDX_W = 3;
    localparam int CFG_W     = RGB_W + 3 * COMP_W;

    localparam logic [CFG_IDX_W-1:0] REG_LIGHT_COUNT = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_AMBIENT     = 3'd1;
    localparam int                   REG_LIGHT0      = 2;

    localparam logic [COLOR_W-1:0] COLOR_MAX = '1;

    typedef struct packed {
        logic signed [COMP_W-1:0] dz;
        logic signed [COMP_W-1:0] dy;
        logic signed [COMP_W-1:0] dx;
        logic [RGB_W-1:0]         rgb;
    } t_light;

    typedef struct packed {
        logic mul;
        logic dot;
    } t_stage_en;

endpackage

FILE: sv/vdl_dot.sv
// vdl_dot: two-stage dot product of one light direction with the normal,
// clamped to zero when not positive or when the light is off. Uses vdl_pkg.
module vdl_dot (
    input  logic                                 i_clk,
    input  vdl_pkg::t_stage_en                   i_en,
    input  logic signed [vdl_pkg::COMP_W-1:0]    i_nx,
    input  logic signed [vdl_pkg::COMP_W-1:0]    i_ny,
    input  logic signed [vdl_pkg::COMP_W-1:0]    i_nz,
    input  vdl_pkg::t_light                      i_light,
    input  logic                                 i_lit,
    output logic [vdl_pkg::DOT_W-1:0]            o_dot
);
    import vdl_pkg::*;

    logic signed [PROD_W-1:0] r_px, r_py, r_pz;
    logic signed [SUM_W-1:0]  n_sum;
    logic [DOT_W-1:0]         r_dot;

    always_ff @(posedge i_clk) begin
        if (i_en.mul) begin
            r_px <= i_nx * i_light.dx;
            r_py <= i_ny * i_light.dy;
            r_pz <= i_nz * i_light.dz;
        end
    end

    assign n_sum = SUM_W'(r_px) + SUM_W'(r_py) + SUM_W'(r_pz);

    always_ff @(posedge i_clk) begin
        if (i_en.dot) begin
            r_dot <= (i_lit && n_sum > 0) ? n_sum[DOT_W-1:0] : '0;
        end
    end

    assign o_dot = r_dot;

endmodule

FILE: sv/vertex_diffuse_lighting_core.sv
// vertex_diffuse_lighting_core: Lambert diffuse lighting, one vertex per cycle unless stalled.
// Depends on vdl_pkg and vdl_dot.
//
//   channel | direction | handshake         | payload
//   cfg     | in        | i_cfg_we          | i_cfg_index, i_cfg_data
//   normal  | in        | i_valid / o_stall | i_normal_x, i_normal_y, i_normal_z
//   color   | out       | o_valid / i_stall | o_red, o_green, o_blue
//
// Five register stages: products, dot, color scale, pair sums, final sum.
// One request per cycle sustained while i_stall stays low.
// Each stage holds only when full and the next one is held, so bubbles close up.
// Synchronous active-low reset clears valid bits and config registers.
module vertex_diffuse_lighting_core (
    input  logic                                 i_clk,
    input  logic                                 i_rst_n,
    input  logic                                 i_cfg_we,
    input  logic [vdl_pkg::CFG_IDX_W-1:0]        i_cfg_index,
    input  logic [vdl_pkg::CFG_W-1:0]            i_cfg_data,
    input  logic                                 i_valid,
    output logic                                 o_stall,
    input  logic signed [vdl_pkg::COMP_W-1:0]    i_normal_x,
    input  logic signed [vdl_pkg::COMP_W-1:0]    i_normal_y,
    input  logic signed [vdl_pkg::COMP_W-1:0]    i_normal_z,
    output logic                                 o_valid,
    input  logic                                 i_stall,
    output logic [vdl_pkg::COLOR_W-1:0]          o_red,
    output logic [vdl_pkg::COLOR_W-1:0]          o_green,
    output logic [vdl_pkg::COLOR_W-1:0]          o_blue
);
    import vdl_pkg::*;

    logic [CNT_W-1:0] r_light_count;
    logic [RGB_W-1:0] r_ambient;
    t_light           r_light [MAX_LIGHTS];
    logic [CNT_W-1:0] n_count;

    logic r_v1, r_v2, r_v3, r_v4, r_v5;
    logic en1, en2, en3, en4, en5;
    t_stage_en dot_en;

    logic [DOT_W-1:0]   dot     [MAX_LIGHTS];
    logic [CPROD_W-1:0] r_cprod [MAX_LIGHTS][3];
    logic [ACC_W-1:0]   r_psum  [NPAIR][3];
    logic [ACC_W-1:0]   r_amb   [3];
    logic [ACC_W-1:0]   n_acc   [3];
    logic [COLOR_W-1:0] n_out   [3];
    logic [COLOR_W-1:0] r_out   [3];

    // configuration
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_light_count <= '0;
            r_ambient     <= '0;
            for (int l = 0; l < MAX_LIGHTS; l++) begin
                r_light[l] <= '0;
            end
        end else if (i_cfg_we) begin
            if (i_cfg_index == REG_LIGHT_COUNT) begin
                r_light_count <= i_cfg_data[CNT_W-1:0];
            end
            if (i_cfg_index == REG_AMBIENT) begin
                r_ambient <= i_cfg_data[RGB_W-1:0];
            end
            for (int l = 0; l < MAX_LIGHTS; l++) begin
                if (i_cfg_index == CFG_IDX_W'(REG_LIGHT0 + l)) begin
                    r_light[l] <= t_light'(i_cfg_data);
                end
            end
        end
    end

    assign n_count = (r_light_count > CNT_W'(MAX_LIGHTS)) ? CNT_W'(MAX_LIGHTS)
                                                          : r_light_count;

    // stage enables
    assign en5 = !r_v5 || !i_stall;
    assign en4 = !r_v4 || en5;
    assign en3 = !r_v3 || en4;
    assign en2 = !r_v2 || en3;
    assign en1 = !r_v1 || en2;
    assign o_stall = !en1;

    assign dot_en.mul = en1;
    assign dot_en.dot = en2;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1 <= 1'b0;
            r_v2 <= 1'b0;
            r_v3 <= 1'b0;
            r_v4 <= 1'b0;
            r_v5 <= 1'b0;
        end else begin
            if (en1) r_v1 <= i_valid;
            if (en2) r_v2 <= r_v1;
            if (en3) r_v3 <= r_v2;
            if (en4) r_v4 <= r_v3;
            if (en5) r_v5 <= r_v4;
        end
    end

    // stages 1-2: per-light dot products
    for (genvar l = 0; l < MAX_LIGHTS; l++) begin : g_light
        vdl_dot u_dot (
            .i_clk   (i_clk),
            .i_en    (dot_en),
            .i_nx    (i_normal_x),
            .i_ny    (i_normal_y),
            .i_nz    (i_normal_z),
            .i_light (r_light[l]),
            .i_lit   (CNT_W'(l) < n_count),
            .o_dot   (dot[l])
        );

        // stage 3: scale by light color
        always_ff @(posedge i_clk) begin
            if (en3) begin
                for (int k = 0; k < 3; k++) begin
                    r_cprod[l][k] <=
                        CPROD_W'(r_light[l].rgb[k*COLOR_W +: COLOR_W]) * CPROD_W'(dot[l]);
                end
            end
        end
    end

    // stage 4: pair sums and ambient term
    for (genvar j = 0; j < NPAIR; j++) begin : g_pair
        always_ff @(posedge i_clk) begin
            if (en4) begin
                for (int k = 0; k < 3; k++) begin
                    if (2 * j + 1 < MAX_LIGHTS) begin
                        r_psum[j][k] <= ACC_W'(r_cprod[2*j][k])
                                      + ACC_W'(r_cprod[(2*j+1) % MAX_LIGHTS][k]);
                    end else begin
                        r_psum[j][k] <= ACC_W'(r_cprod[2*j][k]);
                    end
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (en4) begin
            for (int k = 0; k < 3; k++) begin
                r_amb[k] <= ACC_W'(r_ambient[k*COLOR_W +: COLOR_W]) << SHIFT;
            end
        end
    end

    // stage 5: final sum, truncate, saturate
    always_comb begin
        for (int k = 0; k < 3; k++) begin
            n_acc[k] = r_amb[k];
            for (int j = 0; j < NPAIR; j++) begin
                n_acc[k] = n_acc[k] + r_psum[j][k];
            end
            n_out[k] = (|n_acc[k][ACC_W-1:SHIFT+COLOR_W]) ? COLOR_MAX
                                                          : n_acc[k][SHIFT +: COLOR_W];
        end
    end

    always_ff @(posedge i_clk) begin
        if (en5) begin
            for (int k = 0; k < 3; k++) begin
                r_out[k] <= n_out[k];
            end
        end
    end

    assign o_valid = r_v5;
    assign o_red   = r_out[0];
    assign o_green = r_out[1];
    assign o_blue  = r_out[2];

`ifndef SYNTHESIS
    a_full_stall: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_v1 && r_v2 && r_v3 && r_v4 && r_v5 && i_stall) |-> o_stall)
        else $error("full stalled pipeline accepts a request");
    a_empty_ready: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !r_v1 |-> !o_stall)
        else $error("empty first stage stalls input");
    a_accept_fill: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_valid && !o_stall) |=> r_v1)
        else $error("accepted request not in first stage");
    a_reset_clear: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_valid)
        else $error("output valid after reset");
`endif

endmodule
